>>> design/ttq_pkg.sv
package ttq_pkg;

  localparam int COORD_BITS   = 10;
  localparam int TIMEOUT_BITS = 16;
  localparam int SETTLE_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [SETTLE_BITS-1:0] NIB_MAX = '1;

  // Register reset values
  localparam logic [COORD_BITS-1:0]   RESET_LEFT   = COORD_BITS'(60);
  localparam logic [COORD_BITS-1:0]   RESET_TOP    = COORD_BITS'(288);
  localparam logic [COORD_BITS-1:0]   RESET_RIGHT  = COORD_BITS'(180);
  localparam logic [COORD_BITS-1:0]   RESET_BOTTOM = COORD_BITS'(318);
  localparam logic [SETTLE_BITS-1:0]  RESET_SETTLE = SETTLE_BITS'(3);

  // Result event codes
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_TIMEOUT = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;
  localparam logic [1:0] EV_UNUSED  = 2'd3;

  // Input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RECT_LEFT      = 3'd0,
    REG_RECT_TOP       = 3'd1,
    REG_RECT_RIGHT     = 3'd2,
    REG_RECT_BOTTOM    = 3'd3,
    REG_PRESS_TIMEOUT  = 3'd4,
    REG_PRESS_SETTLE   = 3'd5,
    REG_RELEASE_SETTLE = 3'd6
  } reg_index_t;

  typedef enum logic {
    PH_WAIT_PRESS   = 1'b0,
    PH_WAIT_RELEASE = 1'b1
  } phase_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   rect_left;
    logic [COORD_BITS-1:0]   rect_top;
    logic [COORD_BITS-1:0]   rect_right;
    logic [COORD_BITS-1:0]   rect_bottom;
    logic [TIMEOUT_BITS-1:0] press_timeout;
    logic [SETTLE_BITS-1:0]  press_settle;
    logic [SETTLE_BITS-1:0]  release_settle;
  } cfg_t;

  typedef struct packed {
    logic                  mode;
    logic                  touched;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            event_res;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  inside_res;
  } out_item_t;

  // Half-open rectangle test: left/top inclusive, right/bottom exclusive.
  function automatic logic in_rect(input logic [COORD_BITS-1:0] x,
                                   input logic [COORD_BITS-1:0] y,
                                   input cfg_t c);
    in_rect = (x >= c.rect_left) && (x < c.rect_right) &&
              (y >= c.rect_top) && (y < c.rect_bottom);
  endfunction

endpackage

>>> design/ttq_cfg.sv
module ttq_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ttq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ttq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output ttq_pkg::cfg_t                        cfg
);
  import ttq_pkg::*;

  // Writes are registered directly, so the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_left      <= RESET_LEFT;
      cfg.rect_top       <= RESET_TOP;
      cfg.rect_right     <= RESET_RIGHT;
      cfg.rect_bottom    <= RESET_BOTTOM;
      cfg.press_timeout  <= '0;
      cfg.press_settle   <= RESET_SETTLE;
      cfg.release_settle <= RESET_SETTLE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RECT_LEFT:      cfg.rect_left      <= cfg_data[COORD_BITS-1:0];
        REG_RECT_TOP:       cfg.rect_top       <= cfg_data[COORD_BITS-1:0];
        REG_RECT_RIGHT:     cfg.rect_right     <= cfg_data[COORD_BITS-1:0];
        REG_RECT_BOTTOM:    cfg.rect_bottom    <= cfg_data[COORD_BITS-1:0];
        REG_PRESS_TIMEOUT:  cfg.press_timeout  <= cfg_data[TIMEOUT_BITS-1:0];
        REG_PRESS_SETTLE:   cfg.press_settle   <= cfg_data[SETTLE_BITS-1:0];
        REG_RELEASE_SETTLE: cfg.release_settle <= cfg_data[SETTLE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/ttq_core.sv
module ttq_core #(
  parameter int TICK_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ttq_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  ttq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ttq_pkg::out_item_t out_data
);
  import ttq_pkg::*;

  localparam int CMP_BITS = (TICK_BITS > TIMEOUT_BITS) ? TICK_BITS : TIMEOUT_BITS;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  // Input register
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_fire;

  // Qualifier state
  phase_t                 phase, phase_next;
  logic [SETTLE_BITS-1:0] settle_count, settle_count_next;
  logic [SETTLE_BITS-1:0] lost_count, lost_count_next;
  logic [TICK_BITS-1:0]   elapsed, elapsed_next;
  logic [COORD_BITS-1:0]  press_x, press_x_next, press_y, press_y_next;
  logic [COORD_BITS-1:0]  last_x, last_x_next, last_y, last_y_next;

  logic [SETTLE_BITS-1:0] settle_inc, lost_inc;
  logic [TICK_BITS-1:0]   elapsed_inc;
  logic                   timeout_hit;
  logic                   res_valid;
  out_item_t              res;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  assign settle_inc  = (settle_count == NIB_MAX) ? settle_count
                                                 : settle_count + SETTLE_BITS'(1);
  assign lost_inc    = (lost_count == NIB_MAX) ? lost_count
                                               : lost_count + SETTLE_BITS'(1);
  assign elapsed_inc = (elapsed == TICK_MAX) ? elapsed : elapsed + TICK_BITS'(1);
  assign timeout_hit = (CMP_BITS'(elapsed_inc) >= CMP_BITS'(cfg.press_timeout)) ||
                       (elapsed_inc == TICK_MAX);

  always_comb begin
    phase_next        = phase;
    settle_count_next = settle_count;
    lost_count_next   = lost_count;
    elapsed_next      = elapsed;
    press_x_next      = press_x;
    press_y_next      = press_y;
    last_x_next       = last_x;
    last_y_next       = last_y;
    res_valid         = 1'b0;
    res               = '0;
    if (s1_fire) begin
      unique case (phase)
        PH_WAIT_PRESS: begin
          if (s1_item.mode == MODE_TICK) begin
            if (cfg.press_timeout != '0) begin
              if (timeout_hit) begin
                elapsed_next      = '0;
                settle_count_next = '0;
                res_valid         = 1'b1;
                res.event_res     = EV_TIMEOUT;
              end else begin
                elapsed_next = elapsed_inc;
              end
            end
          end else if (!s1_item.touched) begin
            settle_count_next = '0;
          end else if (settle_inc >= cfg.press_settle) begin
            press_x_next      = s1_item.x_coord;
            press_y_next      = s1_item.y_coord;
            last_x_next       = s1_item.x_coord;
            last_y_next       = s1_item.y_coord;
            phase_next        = PH_WAIT_RELEASE;
            settle_count_next = '0;
            lost_count_next   = '0;
            elapsed_next      = '0;
            res_valid         = 1'b1;
            res.event_res     = EV_PRESS;
            res.pos_x         = s1_item.x_coord;
            res.pos_y         = s1_item.y_coord;
            res.inside_res    = in_rect(s1_item.x_coord, s1_item.y_coord, cfg);
          end else begin
            settle_count_next = settle_inc;
          end
        end
        PH_WAIT_RELEASE: begin
          if (s1_item.mode == MODE_TICK) begin
            // ticks are ignored once pressed
          end else if (s1_item.touched) begin
            last_x_next     = s1_item.x_coord;
            last_y_next     = s1_item.y_coord;
            lost_count_next = '0;
          end else if (lost_inc >= cfg.release_settle) begin
            phase_next        = PH_WAIT_PRESS;
            lost_count_next   = '0;
            settle_count_next = '0;
            elapsed_next      = '0;
            res_valid         = 1'b1;
            res.event_res     = EV_RELEASE;
            res.pos_x         = last_x;
            res.pos_y         = last_y;
            res.inside_res    = in_rect(press_x, press_y, cfg) &&
                                in_rect(last_x, last_y, cfg);
          end else begin
            lost_count_next = lost_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_PRESS;
      settle_count <= '0;
      lost_count   <= '0;
      elapsed      <= '0;
    end else begin
      phase        <= phase_next;
      settle_count <= settle_count_next;
      lost_count   <= lost_count_next;
      elapsed      <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    press_x <= press_x_next;
    press_y <= press_y_next;
    last_x  <= last_x_next;
    last_y  <= last_y_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_data <= res;
    end
  end

endmodule

>>> design/touch_tap_qualifier.sv
// Touch press/release qualifier. Each input beat is either a touch poll sample
// (mode 0: touched flag plus x/y) or one time tick (mode 1). Waiting for a
// press, consecutive touched samples are counted; at press_settle the block
// emits a press beat with the point and whether it lies in the half-open
// button rectangle, then waits for release. Touched samples during release
// wait track the last point; release_settle consecutive untouched samples emit
// a release beat at the last point, inside set only if press and release
// points both lie in the rectangle. A nonzero press_timeout lets ticks end a
// press wait with a timeout beat (point and inside zero); the tick counter is
// TICK_BITS wide and saturates, which also ends the wait. Each input beat
// yields zero or one result beat. A beat accepted into the input register has
// its result, if any, loaded into the result register as it leaves the input
// register. One beat is accepted every cycle as long as the result register
// drains, so in_ready follows out_ready combinationally when both stages hold
// a beat. Configuration writes (index 0..6, index 7 ignored) take effect on
// the next cycle and must be issued only while no beat is in flight.
module touch_tap_qualifier #(
  parameter int TICK_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ttq_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ttq_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ttq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ttq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ttq_pkg::*;

  cfg_t cfg;

  // Register file: rectangle, timeout and settle counts.
  ttq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register, qualifier state and result register.
  ttq_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/ttq_checker.sv
module ttq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ttq_pkg::out_item_t out_data
);
  import ttq_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Timeout beats carry no point.
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res == EV_TIMEOUT |->
      out_data.pos_x == '0 && out_data.pos_y == '0 && !out_data.inside_res)
    else $error("timeout beat carries a point");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.event_res != EV_UNUSED)
    else $error("unused event code on output");

  // An empty result register never back-pressures the input.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind touch_tap_qualifier ttq_checker u_ttq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
